// ----- rtl/core/qrdca_pkg.sv -----
// Shared types, codes and lookup functions for the QR data codeword assembler.
package qrdca_pkg;

    // item kinds carried on s_tuser
    localparam logic [1:0] MODE_HEADER = 2'd0;
    localparam logic [1:0] MODE_CHAR   = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;
    localparam logic [1:0] MODE_PAD    = 2'd3;

    // segment encodings
    localparam logic [1:0] ENC_NUMERIC  = 2'd0;
    localparam logic [1:0] ENC_ALNUM    = 2'd1;
    localparam logic [1:0] ENC_BYTE     = 2'd2;
    localparam logic [1:0] ENC_RESERVED = 2'd3;

    // result error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
    localparam logic [2:0] ERR_CAPACITY = 3'd2;
    localparam logic [2:0] ERR_COUNT    = 3'd3;
    localparam logic [2:0] ERR_SEQUENCE = 3'd4;

    // configuration register indexes
    localparam logic CFG_IDX_CLASS    = 1'b0;
    localparam logic CFG_IDX_CAPACITY = 1'b1;

    localparam logic [15:0] CAPACITY_RESET = 16'd152;

    localparam logic [7:0] PAD_BYTE_EVEN = 8'hEC;
    localparam logic [7:0] PAD_BYTE_ODD  = 8'h11;

    localparam int CHUNK_VAL_W = 20;   // mode indicator plus widest count
    localparam int CHUNK_LEN_W = 5;
    localparam int QUEUE_DEPTH = 4;

    // one bit field handed from front to back
    typedef struct packed {
        logic [2:0]             err;
        logic [CHUNK_LEN_W-1:0] len;
        logic [CHUNK_VAL_W-1:0] val;
    } chunk_t;

    // 4-bit mode indicator per encoding
    function automatic logic [3:0] mode_nibble(input logic [1:0] enc);
        logic [3:0] r;
        case (enc)
            ENC_NUMERIC: r = 4'h1;
            ENC_ALNUM:   r = 4'h2;
            default:     r = 4'h4;
        endcase
        return r;
    endfunction

    // character count width per encoding and version class
    function automatic logic [4:0] count_width(input logic [1:0] enc, input logic [1:0] cls);
        logic [4:0] r;
        case (enc)
            ENC_NUMERIC: r = (cls == 2'd0) ? 5'd10 : (cls == 2'd1) ? 5'd12 : 5'd14;
            ENC_ALNUM:   r = (cls == 2'd0) ? 5'd9  : (cls == 2'd1) ? 5'd11 : 5'd13;
            default:     r = (cls == 2'd0) ? 5'd8  : 5'd16;
        endcase
        return r;
    endfunction

    // bits for a numeric group of 1, 2 or 3 digits
    function automatic logic [4:0] group_bits(input logic [1:0] len);
        logic [4:0] r;
        case (len)
            2'd1:    r = 5'd4;
            2'd2:    r = 5'd7;
            2'd3:    r = 5'd10;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // alphanumeric symbol index, bit 6 set when the character is in the set
    function automatic logic [6:0] alnum_index(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41 + 8'd10)};
        end else begin
            case (c)
                8'h20:   r = {1'b1, 6'd36};
                8'h24:   r = {1'b1, 6'd37};
                8'h25:   r = {1'b1, 6'd38};
                8'h2A:   r = {1'b1, 6'd39};
                8'h2B:   r = {1'b1, 6'd40};
                8'h2D:   r = {1'b1, 6'd41};
                8'h2E:   r = {1'b1, 6'd42};
                8'h2F:   r = {1'b1, 6'd43};
                8'h3A:   r = {1'b1, 6'd44};
                default: r = 7'd0;
            endcase
        end
        return r;
    endfunction

    // total + n stays within the capacity
    function automatic logic fits(input logic [15:0] total, input logic [4:0] n,
                                  input logic [15:0] cap);
        return ({1'b0, total} + 17'(n)) <= {1'b0, cap};
    endfunction

endpackage

// ----- rtl/core/qrdca_front.sv -----
// Front end: checks each item, tracks segment state and emits at most one bit field per item.
module qrdca_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [1:0]        mode,
    input  logic [1:0]        segment_encoding,
    input  logic [15:0]       seg_count,
    input  logic [7:0]        character,
    input  logic [1:0]        count_class,
    input  logic [15:0]       eff_cap,
    output logic              push,
    output qrdca_pkg::chunk_t chunk
);
    import qrdca_pkg::*;

    logic [15:0] total_reg, total_next;
    logic [1:0]  enc_reg, enc_next;
    logic [15:0] rem_reg, rem_next;
    logic [9:0]  grp_val_reg, grp_val_next;
    logic [1:0]  grp_len_reg, grp_len_next;
    logic [5:0]  held_reg, held_next;
    logic        half_reg, half_next;
    logic        toggle_reg, toggle_next;
    logic        done_reg, done_next;

    logic [1:0]  cls;
    logic [4:0]  cw;
    logic [4:0]  hdr_len;
    logic [3:0]  digit;
    logic [13:0] num_val;
    logic [1:0]  num_len;
    logic [4:0]  num_bits;
    logic [6:0]  aidx;
    logic [10:0] pair_val;
    logic        last_char;
    logic [16:0] room;
    logic [4:0]  term;
    logic [15:0] after_term;
    logic [4:0]  fill;
    logic [4:0]  fin_len;
    chunk_t      c;

    always_comb begin
        cls       = (count_class == 2'd3) ? 2'd2 : count_class;
        cw        = count_width(segment_encoding, cls);
        hdr_len   = cw + 5'd4;
        digit     = 4'(character - 8'h30);
        num_val   = 14'(grp_val_reg) * 14'd10 + 14'(digit);
        num_len   = grp_len_reg + 2'd1;
        num_bits  = group_bits(num_len);
        aidx      = alnum_index(character);
        pair_val  = 11'(held_reg) * 11'd45 + 11'(aidx[5:0]);
        last_char = (rem_reg == 16'd1);
        // terminator is up to four zeros, then zero fill to a byte boundary
        room       = {1'b0, eff_cap} - {1'b0, total_reg};
        term       = room[16] ? 5'd4 : (room > 17'd4) ? 5'd4 : 5'(room);
        after_term = total_reg + 16'(term);
        fill       = (after_term[2:0] == 3'd0) ? 5'd0 : 5'(4'd8 - {1'b0, after_term[2:0]});
        fin_len    = term + fill;

        total_next   = total_reg;
        enc_next     = enc_reg;
        rem_next     = rem_reg;
        grp_val_next = grp_val_reg;
        grp_len_next = grp_len_reg;
        held_next    = held_reg;
        half_next    = half_reg;
        toggle_next  = toggle_reg;
        done_next    = done_reg;
        c.err = ERR_NONE;
        c.len = '0;
        c.val = '0;

        case (mode)
            MODE_HEADER: begin
                if (done_reg || rem_reg != 16'd0 || segment_encoding == ENC_RESERVED) begin
                    c.err = ERR_SEQUENCE;
                end else if (cw < 5'd16 && (seg_count >> cw) != 16'd0) begin
                    c.err = ERR_COUNT;
                end else if (!fits(total_reg, hdr_len, eff_cap)) begin
                    c.err = ERR_CAPACITY;
                end else begin
                    c.len        = hdr_len;
                    c.val        = (CHUNK_VAL_W'(mode_nibble(segment_encoding)) << cw)
                                 | CHUNK_VAL_W'(seg_count);
                    enc_next     = segment_encoding;
                    rem_next     = seg_count;
                    grp_val_next = '0;
                    grp_len_next = '0;
                    held_next    = '0;
                    half_next    = 1'b0;
                end
            end
            MODE_CHAR: begin
                if (done_reg || rem_reg == 16'd0) begin
                    c.err = ERR_SEQUENCE;
                end else if (enc_reg == ENC_NUMERIC) begin
                    if (character < 8'h30 || character > 8'h39) begin
                        c.err = ERR_BAD_CHAR;
                    end else if (num_len == 2'd3 || last_char) begin
                        if (!fits(total_reg, num_bits, eff_cap)) begin
                            c.err = ERR_CAPACITY;
                        end else begin
                            c.len        = num_bits;
                            c.val        = CHUNK_VAL_W'(num_val);
                            grp_val_next = '0;
                            grp_len_next = '0;
                        end
                    end else begin
                        grp_val_next = num_val[9:0];
                        grp_len_next = num_len;
                    end
                end else if (enc_reg == ENC_ALNUM) begin
                    if (!aidx[6]) begin
                        c.err = ERR_BAD_CHAR;
                    end else if (half_reg) begin
                        if (!fits(total_reg, 5'd11, eff_cap)) begin
                            c.err = ERR_CAPACITY;
                        end else begin
                            c.len     = 5'd11;
                            c.val     = CHUNK_VAL_W'(pair_val);
                            half_next = 1'b0;
                            held_next = '0;
                        end
                    end else if (last_char) begin
                        if (!fits(total_reg, 5'd6, eff_cap)) begin
                            c.err = ERR_CAPACITY;
                        end else begin
                            c.len = 5'd6;
                            c.val = CHUNK_VAL_W'(aidx[5:0]);
                        end
                    end else begin
                        held_next = aidx[5:0];
                        half_next = 1'b1;
                    end
                end else begin
                    if (!fits(total_reg, 5'd8, eff_cap)) begin
                        c.err = ERR_CAPACITY;
                    end else begin
                        c.len = 5'd8;
                        c.val = CHUNK_VAL_W'(character);
                    end
                end
                if (c.err == ERR_NONE) begin
                    rem_next = rem_reg - 16'd1;
                end else begin
                    // a rejected character leaves the segment untouched
                    grp_val_next = grp_val_reg;
                    grp_len_next = grp_len_reg;
                    held_next    = held_reg;
                    half_next    = half_reg;
                end
            end
            MODE_FINISH: begin
                if (done_reg || rem_reg != 16'd0) begin
                    c.err = ERR_SEQUENCE;
                end else begin
                    c.len     = fin_len;
                    done_next = 1'b1;
                end
            end
            default: begin
                if (!done_reg) begin
                    c.err = ERR_SEQUENCE;
                end else if (!fits(total_reg, 5'd8, eff_cap)) begin
                    c.err = ERR_CAPACITY;
                end else begin
                    c.len       = 5'd8;
                    c.val       = CHUNK_VAL_W'(toggle_reg ? PAD_BYTE_ODD : PAD_BYTE_EVEN);
                    toggle_next = ~toggle_reg;
                end
            end
        endcase

        total_next = total_reg + 16'(c.len);
        chunk      = c;
        // beats without bits and without error produce nothing downstream
        push       = accept && (c.err != ERR_NONE || c.len != 5'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= '0;
            enc_reg     <= '0;
            rem_reg     <= '0;
            grp_val_reg <= '0;
            grp_len_reg <= '0;
            held_reg    <= '0;
            half_reg    <= 1'b0;
            toggle_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end else if (accept) begin
            total_reg   <= total_next;
            enc_reg     <= enc_next;
            rem_reg     <= rem_next;
            grp_val_reg <= grp_val_next;
            grp_len_reg <= grp_len_next;
            held_reg    <= held_next;
            half_reg    <= half_next;
            toggle_reg  <= toggle_next;
            done_reg    <= done_next;
        end
    end

endmodule

// ----- rtl/core/qrdca_fifo.sv -----
// Short queue of bit fields between the front and back ends.
module qrdca_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  qrdca_pkg::chunk_t wr_data,
    input  logic              pop,
    output qrdca_pkg::chunk_t rd_data,
    output logic              full,
    output logic              empty
);
    import qrdca_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    chunk_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   cnt_reg;

    assign full    = (cnt_reg == (PTR_W+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/core/qrdca_back.sv -----
// Back end: merges bit fields into the accumulator and sends completed codewords and error beats.
module qrdca_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  qrdca_pkg::chunk_t q_data,
    input  logic              q_empty,
    output logic              q_pop,
    input  logic [15:0]       eff_cap,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [7:0]        m_codeword,
    output logic              m_last,
    output logic              m_final,
    output logic [2:0]        m_err
);
    import qrdca_pkg::*;

    logic [31:0] acc_reg, acc_next;
    logic [4:0]  pend_reg, pend_next;
    logic [15:0] done_reg, done_next;
    logic        mv_reg, mv_next;
    logic [7:0]  cw_reg, cw_next;
    logic        last_reg, last_next;
    logic        fin_reg, fin_next;
    logic [2:0]  err_reg, err_next;

    logic        adv;
    logic        hold_byte;
    logic [31:0] mrg;
    logic [4:0]  p;
    logic        at_cap;

    always_comb begin
        adv       = !mv_reg || m_ready;
        hold_byte = (pend_reg >= 5'd8);
        mrg       = (acc_reg << q_data.len) | 32'(q_data.val);
        p         = pend_reg + q_data.len;
        at_cap    = (({1'b0, done_reg} + 17'd8) == {1'b0, eff_cap});
        q_pop     = adv && !hold_byte && !q_empty;

        acc_next  = acc_reg;
        pend_next = pend_reg;
        done_next = done_reg;
        mv_next   = mv_reg;
        cw_next   = cw_reg;
        last_next = last_reg;
        fin_next  = fin_reg;
        err_next  = err_reg;

        if (adv) begin
            mv_next = 1'b0;
            if (hold_byte) begin
                // leftover byte from the previous field
                mv_next   = 1'b1;
                cw_next   = 8'(acc_reg >> (pend_reg - 5'd8));
                pend_next = pend_reg - 5'd8;
                last_next = (pend_reg < 5'd16);
                fin_next  = at_cap;
                err_next  = ERR_NONE;
                done_next = done_reg + 16'd8;
            end else if (!q_empty) begin
                if (q_data.err != ERR_NONE) begin
                    mv_next   = 1'b1;
                    cw_next   = '0;
                    last_next = 1'b1;
                    fin_next  = 1'b0;
                    err_next  = q_data.err;
                end else begin
                    acc_next = mrg;
                    if (p >= 5'd8) begin
                        mv_next   = 1'b1;
                        cw_next   = 8'(mrg >> (p - 5'd8));
                        pend_next = p - 5'd8;
                        last_next = (p < 5'd16);
                        fin_next  = at_cap;
                        err_next  = ERR_NONE;
                        done_next = done_reg + 16'd8;
                    end else begin
                        pend_next = p;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            done_reg <= '0;
            mv_reg   <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            done_reg <= done_next;
            mv_reg   <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        cw_reg   <= cw_next;
        last_reg <= last_next;
        fin_reg  <= fin_next;
        err_reg  <= err_next;
    end

    assign m_valid    = mv_reg;
    assign m_codeword = cw_reg;
    assign m_last     = last_reg;
    assign m_final    = fin_reg;
    assign m_err      = err_reg;

endmodule

// ----- rtl/core/qr_data_codeword_assembler.sv -----
// Top level of the QR data codeword assembler: config registers, front, queue and back.
// Path: an item's field is written into the queue, then into the back end's output register on m_tvalid.
// Throughput: the front takes one beat per cycle while the four-entry queue has room; the
// back sends one beat per codeword or error (up to three per item), takes a field that
// completes no byte without a beat, and sends one byte per cycle only while m_tready is high.
// Reset: synchronous, active low; clears segment state, queue and output valid, class 0, cap 152.
module qr_data_codeword_assembler #(
    parameter int MAX_DATA_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,   // 0 count_width_class, 1 capacity_bits
    input  logic [15:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [1:0] segment_encoding, [17:2] character count,
                                     // [25:18] character, [31:26] zero
    input  logic [1:0]  s_tuser,     // [1:0] mode
    // codeword stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] codeword
    output logic        m_tlast,     // run_last
    output logic [3:0]  m_tuser      // [0] final_codeword, [3:1] error_code
);
    import qrdca_pkg::*;

    localparam logic [15:0] MAX_BITS = 16'(MAX_DATA_BYTES * 8);

    logic [1:0]  class_reg;
    logic [15:0] cap_reg;
    logic [15:0] cap_masked;
    logic [15:0] eff_cap;

    logic        s_accept;
    logic        push;
    chunk_t      wr_chunk;
    chunk_t      rd_chunk;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    logic        final_cw;
    logic [2:0]  err_code;

    // registers are to be written only while the block is idle; the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            class_reg <= '0;
            cap_reg   <= CAPACITY_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_IDX_CLASS:    class_reg <= cfg_data[1:0];
                CFG_IDX_CAPACITY: cap_reg   <= cfg_data;
                default:          class_reg <= class_reg;
            endcase
        end
    end

    // capacity in whole bytes, capped by the codeword buffer budget
    assign cap_masked = cap_reg & 16'hFFF8;
    assign eff_cap    = (cap_masked < MAX_BITS) ? cap_masked : MAX_BITS;

    // a beat is taken whenever the queue has a free slot
    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    qrdca_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (s_accept),
        .mode             (s_tuser),
        .segment_encoding (s_tdata[1:0]),
        .seg_count        (s_tdata[17:2]),
        .character        (s_tdata[25:18]),
        .count_class      (class_reg),
        .eff_cap          (eff_cap),
        .push             (push),
        .chunk            (wr_chunk)
    );

    qrdca_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (wr_chunk),
        .pop     (q_pop),
        .rd_data (rd_chunk),
        .full    (q_full),
        .empty   (q_empty)
    );

    qrdca_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_data     (rd_chunk),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .eff_cap    (eff_cap),
        .m_ready    (m_tready),
        .m_valid    (m_tvalid),
        .m_codeword (m_tdata),
        .m_last     (m_tlast),
        .m_final    (final_cw),
        .m_err      (err_code)
    );

    assign m_tuser = {err_code, final_cw};

`ifndef SYNTHESIS
    // an error beat is a lone zero codeword closing its run
    a_err_beat_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[3:1] != ERR_NONE) |-> (m_tdata == 8'h00 && m_tlast && !m_tuser[0]))
        else $error("error beat with payload or final flag");

    // the queue is never written while full
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_full))
        else $error("queue overflow");

    // the queue is never read while empty
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_pop && q_empty))
        else $error("queue underflow");

    // reset leaves no codeword on the port
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");
`endif

endmodule
